FILE: design/uniform_grid_bilinear_interpolator_core_defines.svh
// Assertion macros shared by the checker of the bilinear interpolator core.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef UNIFORM_GRID_BILINEAR_INTERPOLATOR_CORE_DEFINES_SVH
`define UNIFORM_GRID_BILINEAR_INTERPOLATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define UGBI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UGBI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ugbi_pkg.sv
// Shared constants and types of the bilinear interpolator core.
// No dependencies.
`default_nettype none

package ugbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GRID_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int BANK_AW    = ADDR_W - 1;
    localparam int PTS_W      = 13;
    localparam int IDX_W      = PTS_W;
    localparam int AFULL_W    = 2 * PTS_W + 1;
    localparam int PROD_W     = 64;
    localparam int CELL_W     = PROD_W - 2 * FRAC_BITS;
    localparam int LERP_W     = 33 + FRAC_BITS + 1;
    localparam int LATENCY    = 10;

    localparam logic [2:0] REG_X_LOWEST  = 3'd0;
    localparam logic [2:0] REG_X_HIGHEST = 3'd1;
    localparam logic [2:0] REG_Y_LOWEST  = 3'd2;
    localparam logic [2:0] REG_Y_HIGHEST = 3'd3;
    localparam logic [2:0] REG_X_RECIP   = 3'd4;
    localparam logic [2:0] REG_Y_RECIP   = 3'd5;
    localparam logic [2:0] REG_X_POINTS  = 3'd6;
    localparam logic [2:0] REG_Y_POINTS  = 3'd7;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic        [31:0] recip;
        logic [PTS_W-1:0]   points;
    } axis_cfg_t;

endpackage

`default_nettype wire

FILE: design/ugbi_locate.sv
// Per-axis cell locator: clamp, offset, scale by reciprocal step, saturate.
// Three register stages; depends on ugbi_pkg.
`default_nettype none

module ugbi_locate
    import ugbi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic signed [31:0]    coord,
    input  wire axis_cfg_t             cfg,
    output logic [IDX_W-1:0]           cell_idx,
    output logic [FRAC_BITS-1:0]       frac
);

    logic signed [32:0]     c_ext;
    logic signed [32:0]     lo_ext;
    logic signed [32:0]     hi_ext;
    logic signed [32:0]     c_sel;
    logic signed [33:0]     d_full;
    logic [31:0]            d_next;
    logic [31:0]            d_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PTS_W-1:0]       n_pts;
    logic [PTS_W-1:0]       lim;
    logic [CELL_W-1:0]      cell_full;
    logic [IDX_W-1:0]       cell_idx_next;
    logic [FRAC_BITS-1:0]   frac_next;
    logic [IDX_W-1:0]       cell_idx_reg;
    logic [FRAC_BITS-1:0]   frac_reg;

    always_comb
    begin
        c_ext  = 33'(coord);
        lo_ext = 33'(cfg.lo);
        hi_ext = 33'(cfg.hi);
        if (c_ext >= hi_ext)
        begin
            c_sel = hi_ext - 33'sd1;
        end
        else if (c_ext <= lo_ext)
        begin
            c_sel = lo_ext;
        end
        else
        begin
            c_sel = c_ext;
        end
        d_full = 34'(c_sel) - 34'(lo_ext);
        d_next = d_full[33] ? 32'd0 : d_full[31:0];
    end

    always_comb
    begin
        n_pts     = (cfg.points < PTS_W'(2)) ? PTS_W'(2) : cfg.points;
        lim       = n_pts - PTS_W'(2);
        cell_full = prod_reg[PROD_W-1:2*FRAC_BITS];
        if (cell_full > CELL_W'(lim))
        begin
            cell_idx_next = lim;
            frac_next     = '1;
        end
        else
        begin
            cell_idx_next = cell_full[IDX_W-1:0];
            frac_next     = prod_reg[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        prod_reg     <= PROD_W'(d_reg) * PROD_W'(cfg.recip);
        cell_idx_reg <= cell_idx_next;
        frac_reg     <= frac_next;
    end

    assign cell_idx = cell_idx_reg;
    assign frac     = frac_reg;

endmodule

`default_nettype wire

FILE: design/ugbi_bank.sv
// One grid bank: one write port, two read ports, registered read data.
// Depends on ugbi_pkg.
`default_nettype none

module ugbi_bank
    import ugbi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [BANK_AW-1:0]   waddr,
    input  wire logic signed [31:0]   wdata,
    input  wire logic [BANK_AW-1:0]   raddr_a,
    input  wire logic [BANK_AW-1:0]   raddr_b,
    output logic signed [31:0]        rdata_a,
    output logic signed [31:0]        rdata_b
);

    logic signed [31:0] mem [2**BANK_AW];
    logic signed [31:0] rdata_a_reg;
    logic signed [31:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: design/uniform_grid_bilinear_interpolator_core.sv
// Top level of the uniform-grid bilinear interpolator.
// Depends on ugbi_pkg, ugbi_locate and ugbi_bank.
//
// Usage:
//   Input beats are taken on start; busy stays low, so one beat per cycle.
//   kind selects a grid write (entry_index, entry_value) or a query
//   (coord_x, coord_y). A query returns interp_value on done for one cycle;
//   a write returns nothing.
//   Throughput: one beat per cycle, set by a ten-stage pipeline with the
//   grid split into even and odd address banks, each read at two addresses,
//   so the four cell corners come out of one memory access.
//   Writes pass through the same stages as queries and hit the banks at the
//   read stage, so every query sees exactly the writes taken before it.
//   Configuration: wr_en, wr_index, wr_data; write only while idle.
//   Reset: configuration registers return to their defaults and in-flight
//   beats are dropped; grid contents stay undefined until written.
//   The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module uniform_grid_bilinear_interpolator_core
    import ugbi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                kind,
    input  wire logic [11:0]         entry_index,
    input  wire logic signed [31:0]  entry_value,
    input  wire logic signed [31:0]  coord_x,
    input  wire logic signed [31:0]  coord_y,
    output logic                     done,
    output logic signed [31:0]       interp_value,
    input  wire logic                wr_en,
    input  wire logic [2:0]          wr_index,
    input  wire logic [31:0]         wr_data
);

    localparam logic signed [LERP_W-1:0] HALF = LERP_W'(1) <<< (FRAC_BITS - 1);

    axis_cfg_t x_cfg_reg;
    axis_cfg_t y_cfg_reg;

    logic                   accept;
    logic [LATENCY:1]       vld_reg;
    logic [LATENCY:1]       qry_reg;

    logic signed [31:0]     cx_reg;
    logic signed [31:0]     cy_reg;
    logic [ADDR_W-1:0]      widx_reg [1:5];
    logic signed [31:0]     wval_reg [1:5];

    logic [IDX_W-1:0]       xi;
    logic [IDX_W-1:0]       yi;
    logic [FRAC_BITS-1:0]   xf;
    logic [FRAC_BITS-1:0]   yf;
    logic [PTS_W-1:0]       yn;
    logic [AFULL_W-1:0]     a00_next;

    logic [AFULL_W-1:0]     a00_reg;
    logic [PTS_W-1:0]       yn_reg;
    logic [FRAC_BITS-1:0]   xf5_reg;
    logic [FRAC_BITS-1:0]   yf5_reg;
    logic [AFULL_W-1:0]     a01;
    logic [AFULL_W-1:0]     a10;
    logic [AFULL_W-1:0]     a11;
    logic                   we_even;
    logic                   we_odd;

    logic signed [31:0]     ev_a;
    logic signed [31:0]     ev_b;
    logic signed [31:0]     od_a;
    logic signed [31:0]     od_b;
    logic [3:0]             oob_reg;
    logic                   sw0_reg;
    logic                   sw1_reg;
    logic [FRAC_BITS-1:0]   xf6_reg;
    logic [FRAC_BITS-1:0]   yf6_reg;

    logic signed [31:0]     v00;
    logic signed [31:0]     v01;
    logic signed [31:0]     v10;
    logic signed [31:0]     v11;
    logic signed [LERP_W-1:0] p0_reg;
    logic signed [LERP_W-1:0] p1_reg;
    logic signed [31:0]     v00_reg;
    logic signed [31:0]     v10_reg;
    logic [FRAC_BITS-1:0]   xf7_reg;

    logic signed [LERP_W-1:0] sh0;
    logic signed [LERP_W-1:0] sh1;
    logic signed [33:0]     c0_next;
    logic signed [33:0]     c1_next;
    logic signed [31:0]     c0_reg;
    logic signed [31:0]     c1_reg;
    logic [FRAC_BITS-1:0]   xf8_reg;

    logic signed [LERP_W-1:0] px_reg;
    logic signed [31:0]     c0b_reg;
    logic signed [LERP_W-1:0] shx;
    logic signed [33:0]     r_full;
    logic signed [31:0]     r_next;
    logic signed [31:0]     res_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_cfg_reg <= '{lo: 32'sd0, hi: 32'sd65536, recip: 32'd65536, points: PTS_W'(2)};
            y_cfg_reg <= '{lo: 32'sd0, hi: 32'sd65536, recip: 32'd65536, points: PTS_W'(2)};
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_X_LOWEST:  x_cfg_reg.lo     <= wr_data;
                REG_X_HIGHEST: x_cfg_reg.hi     <= wr_data;
                REG_Y_LOWEST:  y_cfg_reg.lo     <= wr_data;
                REG_Y_HIGHEST: y_cfg_reg.hi     <= wr_data;
                REG_X_RECIP:   x_cfg_reg.recip  <= wr_data;
                REG_Y_RECIP:   y_cfg_reg.recip  <= wr_data;
                REG_X_POINTS:  x_cfg_reg.points <= wr_data[PTS_W-1:0];
                REG_Y_POINTS:  y_cfg_reg.points <= wr_data[PTS_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qry_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-1:1], accept};
            qry_reg <= {qry_reg[LATENCY-1:1], kind == KIND_QUERY};
        end
    end

    // stage 1 and the write side band
    always_ff @(posedge clk)
    begin
        cx_reg      <= coord_x;
        cy_reg      <= coord_y;
        widx_reg[1] <= entry_index;
        wval_reg[1] <= entry_value;
        for (int i = 2; i <= 5; i++)
        begin
            widx_reg[i] <= widx_reg[i-1];
            wval_reg[i] <= wval_reg[i-1];
        end
    end

    ugbi_locate u_loc_x
    (
        .clk      (clk),
        .coord    (cx_reg),
        .cfg      (x_cfg_reg),
        .cell_idx (xi),
        .frac     (xf)
    );

    ugbi_locate u_loc_y
    (
        .clk      (clk),
        .coord    (cy_reg),
        .cfg      (y_cfg_reg),
        .cell_idx (yi),
        .frac     (yf)
    );

    // stage 4: base address
    always_comb
    begin
        yn       = (y_cfg_reg.points < PTS_W'(2)) ? PTS_W'(2) : y_cfg_reg.points;
        a00_next = AFULL_W'(xi) * AFULL_W'(yn) + AFULL_W'(yi);
    end

    always_ff @(posedge clk)
    begin
        a00_reg <= a00_next;
        yn_reg  <= yn;
        xf5_reg <= xf;
        yf5_reg <= yf;
    end

    // stage 5: corner addresses, bank access
    always_comb
    begin
        a01     = a00_reg + AFULL_W'(1);
        a10     = a00_reg + AFULL_W'(yn_reg);
        a11     = a10 + AFULL_W'(1);
        we_even = vld_reg[5] && !qry_reg[5] && !widx_reg[5][0];
        we_odd  = vld_reg[5] && !qry_reg[5] && widx_reg[5][0];
    end

    ugbi_bank u_bank_even
    (
        .clk     (clk),
        .we      (we_even),
        .waddr   (widx_reg[5][ADDR_W-1:1]),
        .wdata   (wval_reg[5]),
        .raddr_a (a01[ADDR_W-1:1]),
        .raddr_b (a11[ADDR_W-1:1]),
        .rdata_a (ev_a),
        .rdata_b (ev_b)
    );

    ugbi_bank u_bank_odd
    (
        .clk     (clk),
        .we      (we_odd),
        .waddr   (widx_reg[5][ADDR_W-1:1]),
        .wdata   (wval_reg[5]),
        .raddr_a (a00_reg[ADDR_W-1:1]),
        .raddr_b (a10[ADDR_W-1:1]),
        .rdata_a (od_a),
        .rdata_b (od_b)
    );

    always_ff @(posedge clk)
    begin
        oob_reg[0] <= |a00_reg[AFULL_W-1:ADDR_W];
        oob_reg[1] <= |a01[AFULL_W-1:ADDR_W];
        oob_reg[2] <= |a10[AFULL_W-1:ADDR_W];
        oob_reg[3] <= |a11[AFULL_W-1:ADDR_W];
        sw0_reg    <= a00_reg[0];
        sw1_reg    <= a10[0];
        xf6_reg    <= xf5_reg;
        yf6_reg    <= yf5_reg;
    end

    // stage 6: corner select, blend along y
    always_comb
    begin
        v00 = oob_reg[0] ? 32'sd0 : (sw0_reg ? od_a : ev_a);
        v01 = oob_reg[1] ? 32'sd0 : (sw0_reg ? ev_a : od_a);
        v10 = oob_reg[2] ? 32'sd0 : (sw1_reg ? od_b : ev_b);
        v11 = oob_reg[3] ? 32'sd0 : (sw1_reg ? ev_b : od_b);
    end

    always_ff @(posedge clk)
    begin
        p0_reg  <= LERP_W'(33'(v01) - 33'(v00)) * LERP_W'($signed({1'b0, yf6_reg}));
        p1_reg  <= LERP_W'(33'(v11) - 33'(v10)) * LERP_W'($signed({1'b0, yf6_reg}));
        v00_reg <= v00;
        v10_reg <= v10;
        xf7_reg <= xf6_reg;
    end

    // stage 7: round and add
    always_comb
    begin
        sh0     = (p0_reg + HALF) >>> FRAC_BITS;
        sh1     = (p1_reg + HALF) >>> FRAC_BITS;
        c0_next = 34'(v00_reg) + 34'(sh0);
        c1_next = 34'(v10_reg) + 34'(sh1);
    end

    always_ff @(posedge clk)
    begin
        c0_reg  <= c0_next[31:0];
        c1_reg  <= c1_next[31:0];
        xf8_reg <= xf7_reg;
    end

    // stage 8: blend along x
    always_ff @(posedge clk)
    begin
        px_reg  <= LERP_W'(33'(c1_reg) - 33'(c0_reg)) * LERP_W'($signed({1'b0, xf8_reg}));
        c0b_reg <= c0_reg;
    end

    // stage 9: round, add, saturate
    always_comb
    begin
        shx    = (px_reg + HALF) >>> FRAC_BITS;
        r_full = 34'(c0b_reg) + 34'(shx);
        if (r_full > 34'sh0_7FFF_FFFF)
        begin
            r_next = 32'sh7FFF_FFFF;
        end
        else if (r_full < -34'sh0_8000_0000)
        begin
            r_next = -32'sh8000_0000;
        end
        else
        begin
            r_next = r_full[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= r_next;
    end

    assign done         = vld_reg[LATENCY] && qry_reg[LATENCY];
    assign interp_value = res_reg;

endmodule

`default_nettype wire

FILE: design/ugbi_checker.sv
// Port-level checker for the bilinear interpolator core, bound to the top.
// Depends on ugbi_pkg and the core's assertion macro header.
`default_nettype none

`include "uniform_grid_bilinear_interpolator_core_defines.svh"

module ugbi_checker
    import ugbi_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic kind,
    input wire logic done
);

    `UGBI_ASSERT_IMPL(a_query_gives_result, start && !busy && kind == KIND_QUERY, ##10 done, "query beat lost")
    `UGBI_ASSERT_IMPL(a_write_gives_none, start && !busy && kind == KIND_WRITE, ##10 !done, "write beat produced a result")
    `UGBI_ASSERT_IMPL(a_result_has_source, done, $past(start && !busy && kind == KIND_QUERY, 10), "result without query")
    `UGBI_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind uniform_grid_bilinear_interpolator_core ugbi_checker u_checker (.*);

`default_nettype wire
